/* rtl/jfs_pkg.sv */
// Package: payload types, register codes and sizes for the joint fault supervisor.
package jfs_pkg;

  localparam int COUNT_WIDTH_DEF = 10;

  localparam int LIMIT_W   = 15;
  localparam int TICKS_W   = 10;
  localparam int AGE_W     = 16;
  localparam int TORQUE_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [LIMIT_W-1:0] SHOULDER_LIMIT_RST = LIMIT_W'(1200);
  localparam logic [LIMIT_W-1:0] ELBOW_LIMIT_RST    = LIMIT_W'(600);
  localparam logic [LIMIT_W-1:0] WRIST_LIMIT_RST    = LIMIT_W'(450);
  localparam logic [TICKS_W-1:0] OVERLOAD_TICKS_RST = TICKS_W'(50);
  localparam logic [TICKS_W-1:0] TX_FAIL_TICKS_RST  = TICKS_W'(50);
  localparam logic [AGE_W-1:0]   FB_TIMEOUT_RST     = AGE_W'(200);

  localparam logic [1:0] WRIST_MODE_RUN = 2'd2;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_FEEDBACK = 2'd1,
    FAULT_TORQUE   = 2'd2,
    FAULT_TX       = 2'd3
  } fault_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHOULDER_LIMIT = 3'd0,
    REG_ELBOW_LIMIT    = 3'd1,
    REG_WRIST_LIMIT    = 3'd2,
    REG_OVERLOAD_TICKS = 3'd3,
    REG_TX_FAIL_TICKS  = 3'd4,
    REG_FB_TIMEOUT     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]                 motor_online;
    logic [2:0]                 motor_error;
    logic [AGE_W-1:0]           shoulder_age;
    logic [AGE_W-1:0]           elbow_age;
    logic [AGE_W-1:0]           wrist_age;
    logic [1:0]                 wrist_mode;
    logic signed [TORQUE_W-1:0] shoulder_torque;
    logic signed [TORQUE_W-1:0] elbow_torque;
    logic signed [TORQUE_W-1:0] wrist_torque;
    logic [2:0]                 send_fail;
    logic                       rearm;
  } in_item_t;

  typedef struct packed {
    logic        running;
    fault_code_t fault_code;
    logic        fault_event;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] value;
  } cfg_wr_t;

endpackage

/* rtl/jfs_stream_if.sv */
// Interface: valid/ready channel carrying one payload of type T.
interface jfs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/joint_fault_supervisor.sv */
// Top level: per-tick fault supervisor for a three-joint arm.
//
//  channel  | dir | payload     | transfer
//  ---------+-----+-------------+----------------------------
//  in_s     | in  | in_item_t   | valid && ready, one tick
//  out_s    | out | out_item_t  | valid && ready, one result
//  cfg_s    | in  | cfg_wr_t    | valid && ready, always ready
//
// One tick per cycle sustained while out_s accepts results. A tick is captured
// in the input register, evaluated there against the supervisor state, and its
// result lands in the output register, which drives out_s.valid.
// The state loop (counters, latch) closes in the evaluate stage, so
// consecutive ticks see each other's updates with no bubble.
// A stall on out_s holds both stages; in_s.ready drops only when both are full.
// Reset (rst_n low, synchronous) clears the pipeline, counters and latch and
// loads the default limits; the block reports running 0 until a rearm tick.
module joint_fault_supervisor
  import jfs_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  jfs_stream_if.sink   in_s,
  jfs_stream_if.source out_s,
  jfs_stream_if.sink   cfg_s
);

  localparam int THR_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;
  localparam logic [THR_W-1:0] CNT_MAX = THR_W'({COUNT_WIDTH{1'b1}});

  // Thresholds wider than the counter saturate at its maximum.
  function automatic logic [COUNT_WIDTH-1:0] clamp_thr(input logic [TICKS_W-1:0] t);
    logic [THR_W-1:0] tw;
    tw = THR_W'(t);
    return COUNT_WIDTH'((tw > CNT_MAX) ? CNT_MAX : tw);
  endfunction

  // ---------------- configuration registers ----------------
  logic [LIMIT_W-1:0] shoulder_limit_r;
  logic [LIMIT_W-1:0] elbow_limit_r;
  logic [LIMIT_W-1:0] wrist_limit_r;
  logic [TICKS_W-1:0] overload_ticks_r;
  logic [TICKS_W-1:0] tx_fail_ticks_r;
  logic [AGE_W-1:0]   fb_timeout_r;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shoulder_limit_r <= SHOULDER_LIMIT_RST;
      elbow_limit_r    <= ELBOW_LIMIT_RST;
      wrist_limit_r    <= WRIST_LIMIT_RST;
      overload_ticks_r <= OVERLOAD_TICKS_RST;
      tx_fail_ticks_r  <= TX_FAIL_TICKS_RST;
      fb_timeout_r     <= FB_TIMEOUT_RST;
    end else if (cfg_s.valid) begin
      unique case (cfg_reg_t'(cfg_s.data.index))
        REG_SHOULDER_LIMIT: shoulder_limit_r <= cfg_s.data.value[LIMIT_W-1:0];
        REG_ELBOW_LIMIT:    elbow_limit_r    <= cfg_s.data.value[LIMIT_W-1:0];
        REG_WRIST_LIMIT:    wrist_limit_r    <= cfg_s.data.value[LIMIT_W-1:0];
        REG_OVERLOAD_TICKS: overload_ticks_r <= cfg_s.data.value[TICKS_W-1:0];
        REG_TX_FAIL_TICKS:  tx_fail_ticks_r  <= cfg_s.data.value[TICKS_W-1:0];
        REG_FB_TIMEOUT:     fb_timeout_r     <= cfg_s.data.value[AGE_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  logic      in_v_r;
  in_item_t  in_r;
  logic      out_v_r;
  out_item_t out_r;
  logic      adv;

  // evaluate stage moves on when the output register is free or draining
  assign adv        = in_v_r && (!out_v_r || out_s.ready);
  assign in_s.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_s.ready) begin
      in_v_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      in_r <= in_s.data;
    end
  end

  // ---------------- supervisor state ----------------
  logic [COUNT_WIDTH-1:0] ovl_cnt_r [3];
  logic [COUNT_WIDTH-1:0] ovl_cnt_nxt [3];
  logic [COUNT_WIDTH-1:0] tx_cnt_r;
  logic [COUNT_WIDTH-1:0] tx_cnt_nxt;
  logic                   running_r;
  logic                   running_nxt;
  fault_code_t            code_r;
  fault_code_t            code_nxt;
  logic                   event_nxt;

  // ---------------- per-tick checks ----------------
  logic                   fb_ok;
  logic [2:0]             over;
  logic [LIMIT_W-1:0]     lim [3];
  logic [TORQUE_W-1:0]    trq [3];
  logic [TORQUE_W-1:0]    mag [3];
  logic [COUNT_WIDTH-1:0] ovl_thr;
  logic [COUNT_WIDTH-1:0] tx_thr;

  assign ovl_thr = clamp_thr(overload_ticks_r);
  assign tx_thr  = clamp_thr(tx_fail_ticks_r);

  assign fb_ok = (in_r.motor_online == 3'b111) && (in_r.motor_error == 3'b000) &&
                 (in_r.shoulder_age <= fb_timeout_r) &&
                 (in_r.elbow_age <= fb_timeout_r) &&
                 (in_r.wrist_age <= fb_timeout_r) &&
                 (in_r.wrist_mode == WRIST_MODE_RUN);

  assign lim[0] = shoulder_limit_r;
  assign lim[1] = elbow_limit_r;
  assign lim[2] = wrist_limit_r;
  assign trq[0] = $unsigned(in_r.shoulder_torque);
  assign trq[1] = $unsigned(in_r.elbow_torque);
  assign trq[2] = $unsigned(in_r.wrist_torque);

  // |torque| as unsigned 16 bit; full negative scale gives 32768 exactly
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]  = trq[i][TORQUE_W-1] ? (~trq[i] + TORQUE_W'(1)) : trq[i];
      over[i] = mag[i] > TORQUE_W'(lim[i]);
    end
  end

  always_comb begin
    logic                   trip_t;
    logic [COUNT_WIDTH-1:0] inc;
    ovl_cnt_nxt = ovl_cnt_r;
    tx_cnt_nxt  = tx_cnt_r;
    running_nxt = running_r;
    code_nxt    = code_r;
    event_nxt   = 1'b0;
    trip_t      = 1'b0;
    inc         = '0;
    if (in_r.rearm) begin
      for (int i = 0; i < 3; i++) ovl_cnt_nxt[i] = '0;
      tx_cnt_nxt  = '0;
      running_nxt = 1'b1;
      code_nxt    = FAULT_NONE;
    end else if (running_r) begin
      if (!fb_ok) begin
        tx_cnt_nxt  = '0;
        running_nxt = 1'b0;
        code_nxt    = FAULT_FEEDBACK;
        event_nxt   = 1'b1;
      end else begin
        // joints in order; the first one to trip freezes the rest
        for (int i = 0; i < 3; i++) begin
          if (!trip_t) begin
            if (over[i]) begin
              inc = (ovl_cnt_r[i] < ovl_thr) ? ovl_cnt_r[i] + COUNT_WIDTH'(1) : ovl_cnt_r[i];
              ovl_cnt_nxt[i] = inc;
              trip_t = inc >= ovl_thr;
            end else begin
              ovl_cnt_nxt[i] = '0;
            end
          end
        end
        if (trip_t) begin
          tx_cnt_nxt  = '0;
          running_nxt = 1'b0;
          code_nxt    = FAULT_TORQUE;
          event_nxt   = 1'b1;
        end else if (in_r.send_fail == 3'b000) begin
          tx_cnt_nxt = '0;
        end else begin
          inc = (tx_cnt_r < tx_thr) ? tx_cnt_r + COUNT_WIDTH'(1) : tx_cnt_r;
          if (inc >= tx_thr) begin
            tx_cnt_nxt  = '0;
            running_nxt = 1'b0;
            code_nxt    = FAULT_TX;
            event_nxt   = 1'b1;
          end else begin
            tx_cnt_nxt = inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) ovl_cnt_r[i] <= '0;
      tx_cnt_r  <= '0;
      running_r <= 1'b0;
      code_r    <= FAULT_NONE;
    end else if (adv) begin
      ovl_cnt_r <= ovl_cnt_nxt;
      tx_cnt_r  <= tx_cnt_nxt;
      running_r <= running_nxt;
      code_r    <= code_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_s.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.running     <= running_nxt;
      out_r.fault_code  <= code_nxt;
      out_r.fault_event <= event_nxt;
    end
  end

  assign out_s.valid = out_v_r;
  assign out_s.data  = out_r;

  // ---------------- assertions ----------------
  a_run_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> code_r == FAULT_NONE)
    else $error("running with a latched fault code");

  a_event_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.fault_event |-> !out_r.running && out_r.fault_code != FAULT_NONE)
    else $error("fault event without a latched stop");

  a_rearm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_r.rearm |=> running_r && tx_cnt_r == '0 && code_r == FAULT_NONE)
    else $error("rearm did not clear the supervisor");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the joint fault supervisor: directed ticks, then random ticks.
`timescale 1ns / 100ps

module testbench;
  import jfs_pkg::*;

  localparam int CNT_MAX     = (1 << COUNT_WIDTH_DEF) - 1;
  localparam int CYCLE_LIMIT = 200000;   // watchdog bound for the whole run
  localparam int PHASE_TICKS = 100;      // live ticks per random phase
  localparam int NUM_PHASES  = 8;
  localparam int LONG_STALL  = 90;       // receiver hold-off, in cycles

  // Supervisor settings as the predictor sees them; lim[0] shoulder, [1] elbow, [2] wrist.
  typedef struct packed {
    logic [2:0][LIMIT_W-1:0] lim;
    logic [TICKS_W-1:0]      ovl_thr;
    logic [TICKS_W-1:0]      tx_thr;
    logic [AGE_W-1:0]        fb_to;
  } sup_cfg_t;

  typedef struct packed {
    logic [2:0][COUNT_WIDTH_DEF-1:0] ovl_cnt;
    logic [COUNT_WIDTH_DEF-1:0]      tx_cnt;
    logic                            armed;
    fault_code_t                     code;
  } sup_state_t;

  typedef struct packed {
    sup_state_t st;
    out_item_t  verdict;
  } tick_res_t;

  logic clk;
  logic rst_n = 1'b0;

  // Testbench-side drive registers, known from time zero.
  logic      in_vld  = 1'b0;
  in_item_t  in_dat  = '0;
  logic      out_rdy = 1'b0;
  logic      cfg_vld = 1'b0;
  cfg_wr_t   cfg_dat = '0;

  jfs_stream_if #(.T(in_item_t))  in_ch ();
  jfs_stream_if #(.T(out_item_t)) out_ch ();
  jfs_stream_if #(.T(cfg_wr_t))   cfg_ch ();

  assign in_ch.valid  = in_vld;
  assign in_ch.data   = in_dat;
  assign out_ch.ready = out_rdy;
  assign cfg_ch.valid = cfg_vld;
  assign cfg_ch.data  = cfg_dat;

  joint_fault_supervisor DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch),
    .cfg_s (cfg_ch)
  );

  // Pending ticks (filled by the sequencer) and verdicts still owed by the block.
  in_item_t  tick_q[$];
  out_item_t verdict_q[$];

  // Transfer bookkeeping between the negedge driver and the posedge monitor.
  int unsigned in_sent_cnt = 0;
  int unsigned in_acc_cnt  = 0;

  // Idle percentages and stall requests come from the sequencer;
  // the hold-off countdown belongs to the receiver.
  int snd_idle    = 0;
  int rcv_idle    = 0;
  int stall_reqs  = 0;
  int stall_seen  = 0;
  int stall_left  = 0;

  int errors = 0;
  int cycles = 0;

  // Generator-side copy of state and settings: lets the sequencer know when
  // the block is tripped so it can rearm instead of feeding ignored ticks.
  sup_state_t gen_st;
  sup_cfg_t   gen_cfg;
  bit [2:0]   joint_hot;   // joint currently driven over its limit
  bit         tx_hot;      // sends currently failing

  // Checker-side copy, advanced on every accepted input transfer.
  sup_state_t chk_st;
  sup_cfg_t   chk_cfg;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic sup_cfg_t default_cfg();
    sup_cfg_t c;
    c.lim[0]  = SHOULDER_LIMIT_RST;
    c.lim[1]  = ELBOW_LIMIT_RST;
    c.lim[2]  = WRIST_LIMIT_RST;
    c.ovl_thr = OVERLOAD_TICKS_RST;
    c.tx_thr  = TX_FAIL_TICKS_RST;
    c.fb_to   = FB_TIMEOUT_RST;
    return c;
  endfunction

  // One control tick of the supervisor: returns the next state and the verdict.
  function automatic tick_res_t supervise_tick(sup_state_t st, sup_cfg_t c, in_item_t it);
    tick_res_t   r;
    int          tq[3];
    int          mag;
    int          ovl_lim;
    int          tx_lim;
    bit          fb_ok;
    bit          trip;
    fault_code_t hit;
    tq[0]   = it.shoulder_torque;
    tq[1]   = it.elbow_torque;
    tq[2]   = it.wrist_torque;
    ovl_lim = (c.ovl_thr > CNT_MAX) ? CNT_MAX : int'(c.ovl_thr);
    tx_lim  = (c.tx_thr > CNT_MAX) ? CNT_MAX : int'(c.tx_thr);
    hit     = FAULT_NONE;
    r.verdict.fault_event = 1'b0;
    if (it.rearm) begin
      st.ovl_cnt = '0;
      st.tx_cnt  = '0;
      st.code    = FAULT_NONE;
      st.armed   = 1'b1;
    end else if (st.armed) begin
      fb_ok = (it.motor_online == 3'b111) && (it.motor_error == 3'b000) &&
              (it.shoulder_age <= c.fb_to) && (it.elbow_age <= c.fb_to) &&
              (it.wrist_age <= c.fb_to) && (it.wrist_mode == WRIST_MODE_RUN);
      if (!fb_ok) begin
        hit = FAULT_FEEDBACK;
      end else begin
        // joints in order; the first one to reach the threshold ends the scan
        trip = 1'b0;
        for (int j = 0; j < 3; j++) begin
          if (!trip) begin
            mag = (tq[j] < 0) ? -tq[j] : tq[j];
            if (mag > c.lim[j]) begin
              if (st.ovl_cnt[j] < ovl_lim) st.ovl_cnt[j] = st.ovl_cnt[j] + 1'b1;
              if (st.ovl_cnt[j] >= ovl_lim) trip = 1'b1;
            end else begin
              st.ovl_cnt[j] = '0;
            end
          end
        end
        if (trip) begin
          hit = FAULT_TORQUE;
        end else if (it.send_fail != 3'b000) begin
          if (st.tx_cnt < tx_lim) st.tx_cnt = st.tx_cnt + 1'b1;
          if (st.tx_cnt >= tx_lim) hit = FAULT_TX;
        end else begin
          st.tx_cnt = '0;
        end
      end
      // a fault clears only the transmit counter; overload counts persist
      if (hit != FAULT_NONE) begin
        st.tx_cnt = '0;
        st.armed  = 1'b0;
        st.code   = hit;
        r.verdict.fault_event = 1'b1;
      end
    end
    r.verdict.running    = st.armed;
    r.verdict.fault_code = st.code;
    r.st = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers (sequencer side)
  // ---------------------------------------------------------------------------

  // Queue a tick and advance the generator-side state with it.
  task automatic push_tick(in_item_t it);
    tick_res_t r;
    r      = supervise_tick(gen_st, gen_cfg, it);
    gen_st = r.st;
    tick_q.push_back(it);
  endtask

  // All motors healthy, every age equal to the given value, no torque, no failed sends.
  function automatic in_item_t calm_tick(int age);
    in_item_t it;
    it = '0;
    it.motor_online = 3'b111;
    it.shoulder_age = AGE_W'(age);
    it.elbow_age    = AGE_W'(age);
    it.wrist_age    = AGE_W'(age);
    it.wrist_mode   = WRIST_MODE_RUN;
    return it;
  endfunction

  function automatic in_item_t noise_tick();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  // Torque around the limit: but for an occasional random value, hot joints sit above it, cold ones at or below.
  function automatic logic [TORQUE_W-1:0] pick_torque(int lim, bit hot);
    int mag;
    if ($urandom_range(9) == 0) return TORQUE_W'($urandom());
    if (hot) mag = ($urandom_range(2) == 0) ? lim + 1 : $urandom_range(32768, lim + 1);
    else     mag = ($urandom_range(2) == 0) ? lim : $urandom_range(lim, 0);
    if (mag == 32768) return 16'h8000;
    return $urandom_range(1) ? TORQUE_W'(-mag) : TORQUE_W'(mag);
  endfunction

  function automatic logic [AGE_W-1:0] pick_age(int to);
    return ($urandom_range(3) == 0) ? AGE_W'(to) : AGE_W'($urandom_range(to, 0));
  endfunction

  // A well-formed tick: healthy feedback, torques and sends following the burst flags.
  function automatic in_item_t sane_tick();
    in_item_t it;
    it = '0;
    it.motor_online    = 3'b111;
    it.shoulder_age    = pick_age(gen_cfg.fb_to);
    it.elbow_age       = pick_age(gen_cfg.fb_to);
    it.wrist_age       = pick_age(gen_cfg.fb_to);
    it.wrist_mode      = WRIST_MODE_RUN;
    it.shoulder_torque = pick_torque(gen_cfg.lim[0], joint_hot[0]);
    it.elbow_torque    = pick_torque(gen_cfg.lim[1], joint_hot[1]);
    it.wrist_torque    = pick_torque(gen_cfg.lim[2], joint_hot[2]);
    it.send_fail       = tx_hot ? 3'($urandom_range(7, 1)) : 3'b000;
    return it;
  endfunction

  function automatic in_item_t random_tick();
    in_item_t it;
    int       r;
    int       k;
    // burst flags flip now and then so over-limit and failed-send runs form
    for (int j = 0; j < 3; j++)
      if ($urandom_range(99) < 12) joint_hot[j] = ~joint_hot[j];
    if ($urandom_range(99) < 12) tx_hot = ~tx_hot;
    r = $urandom_range(99);
    k = $urandom_range(2);
    if (!gen_st.armed) begin
      // tripped or not yet armed: mostly rearm, sometimes a tick that is ignored
      if (r < 75) begin
        it = ($urandom_range(1)) ? sane_tick() : noise_tick();
        it.rearm = 1'b1;
      end else begin
        it = noise_tick();
        it.rearm = 1'b0;
      end
      return it;
    end
    it = sane_tick();
    if (r < 5) begin
      it.rearm = 1'b1;
    end else if (r < 8) begin
      it = noise_tick();
    end else if (r < 18) begin
      // one broken feedback condition
      case ($urandom_range(3))
        0: it.motor_online[k] = 1'b0;
        1: it.motor_error[k]  = 1'b1;
        2: begin
          if (gen_cfg.fb_to != 16'hFFFF) begin
            if (k == 0) it.shoulder_age = gen_cfg.fb_to + 1'b1;
            else if (k == 1) it.elbow_age = gen_cfg.fb_to + 1'b1;
            else it.wrist_age = gen_cfg.fb_to + 1'b1;
          end else begin
            it.wrist_mode = 2'd3;
          end
        end
        default: it.wrist_mode = ($urandom_range(2) == 0) ? 2'd3 : 2'($urandom_range(1));
      endcase
    end
    return it;
  endfunction

  function automatic sup_cfg_t phase_cfg(int p);
    sup_cfg_t c;
    if (p == 2) begin
      // top of every range: only a full-scale negative torque can exceed a limit
      c.lim[0] = 15'h7FFF; c.lim[1] = 15'h7FFF; c.lim[2] = 15'h7FFF;
      c.ovl_thr = 10'h3FF; c.tx_thr = 10'h3FF; c.fb_to = 16'hFFFF;
    end else if (p == 5) begin
      // near the bottom of every range: zero limits, one-tick thresholds, zero age allowed
      c.lim[0] = '0; c.lim[1] = '0; c.lim[2] = '0;
      c.ovl_thr = 10'd1; c.tx_thr = 10'd1; c.fb_to = '0;
    end else begin
      for (int j = 0; j < 3; j++) c.lim[j] = LIMIT_W'($urandom_range(3000, 0));
      c.ovl_thr = TICKS_W'($urandom_range(6, 1));
      c.tx_thr  = TICKS_W'($urandom_range(8, 1));
      c.fb_to   = AGE_W'($urandom_range(65535, 50));
      // zero thresholds trip on the first offending tick
      if (p == 7) begin
        c.ovl_thr = '0;
        c.tx_thr  = '0;
      end
    end
    return c;
  endfunction

  // One register write over the cfg channel; valid is left high for the next one.
  task automatic cfg_write(cfg_reg_t idx, int val);
    cfg_wr_t w;
    w.index = idx;
    w.value = CFG_DAT_W'(val);
    @(negedge clk);
    cfg_vld <= 1'b1;
    cfg_dat <= w;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_cfg(sup_cfg_t c);
    cfg_write(REG_SHOULDER_LIMIT, c.lim[0]);
    cfg_write(REG_ELBOW_LIMIT, c.lim[1]);
    cfg_write(REG_WRIST_LIMIT, c.lim[2]);
    cfg_write(REG_OVERLOAD_TICKS, c.ovl_thr);
    cfg_write(REG_TX_FAIL_TICKS, c.tx_thr);
    cfg_write(REG_FB_TIMEOUT, c.fb_to);
    @(negedge clk);
    cfg_vld <= 1'b0;
    gen_cfg = c;
  endtask

  // Sender pause: wait until every queued tick went in and every verdict came out,
  // then let the two-stage pipeline settle.
  task automatic wait_quiet();
    while (tick_q.size() != 0 || in_vld || verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t it;
    int       counted;
    bit       was_armed;
    gen_st    = '0;
    gen_st.code = FAULT_NONE;
    gen_cfg   = default_cfg();
    joint_hot = '0;
    tx_hot    = 1'b0;
    snd_idle  = 22;
    rcv_idle  = 47;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: not armed yet, rearm, feedback faults of each kind.
    it = calm_tick(0);
    push_tick(it);                             // ignored: block waits for rearm
    it = noise_tick();
    it.motor_online = 3'b000;
    it.motor_error  = 3'b111;
    it.rearm        = 1'b1;
    push_tick(it);                             // rearm wins over broken feedback
    it = calm_tick(FB_TIMEOUT_RST);
    it.shoulder_torque = TORQUE_W'(SHOULDER_LIMIT_RST);
    it.elbow_torque    = -$signed({1'b0, ELBOW_LIMIT_RST});
    it.wrist_torque    = TORQUE_W'(WRIST_LIMIT_RST);
    push_tick(it);                             // every value exactly at its bound
    it = calm_tick(FB_TIMEOUT_RST);
    it.shoulder_age = FB_TIMEOUT_RST + 1'b1;
    push_tick(it);                             // stale feedback trips
    push_tick(calm_tick(0));                   // tripped: nothing changes
    it = calm_tick(0); it.rearm = 1'b1;
    push_tick(it);
    it = calm_tick(0); it.wrist_mode = 2'd3;
    push_tick(it);                             // wrist not running
    it = calm_tick(0); it.rearm = 1'b1;
    push_tick(it);
    it = calm_tick(0); it.motor_online = 3'b011;
    push_tick(it);                             // wrist offline
    it = calm_tick(0); it.rearm = 1'b1;
    push_tick(it);
    it = calm_tick(0); it.motor_error = 3'b100;
    push_tick(it);                             // wrist reports an error
    wait_quiet();

    // Directed, tight settings: torque trips on shoulder and elbow, instant tx trip.
    begin
      sup_cfg_t c;
      c.lim[0] = '0; c.lim[1] = 15'h7FFF; c.lim[2] = 15'd100;
      c.ovl_thr = 10'd2; c.tx_thr = 10'd1; c.fb_to = 16'hFFFF;
      load_cfg(c);
    end
    it = calm_tick(0); it.rearm = 1'b1;
    push_tick(it);
    it = calm_tick(16'hFFFF);
    it.shoulder_torque = 16'sd1;
    it.elbow_torque    = 16'sh7FFF;
    it.wrist_torque    = -16'sd101;
    push_tick(it);                             // shoulder and wrist count one
    push_tick(it);                             // shoulder trips, wrist not scanned
    it = calm_tick(0); it.rearm = 1'b1;
    push_tick(it);
    it = calm_tick(0);
    it.elbow_torque = 16'sh8000;               // full-scale negative beats 32767
    it.wrist_torque = 16'sd100;
    push_tick(it);
    push_tick(it);
    it = calm_tick(0); it.rearm = 1'b1;
    push_tick(it);
    it = calm_tick(0); it.send_fail = 3'b100;
    push_tick(it);                             // one failed send trips
    it = calm_tick(0); it.rearm = 1'b1;
    push_tick(it);
    wait_quiet();

    // Directed, zero thresholds: first offending tick trips; feedback has priority.
    begin
      sup_cfg_t c;
      c.lim[0] = 15'h7FFF; c.lim[1] = 15'h7FFF; c.lim[2] = 15'h7FFF;
      c.ovl_thr = '0; c.tx_thr = '0; c.fb_to = 16'd1000;
      load_cfg(c);
    end
    it = calm_tick(1000); it.shoulder_torque = 16'sh8000;
    push_tick(it);
    it = calm_tick(0); it.rearm = 1'b1;
    push_tick(it);
    it = calm_tick(0); it.send_fail = 3'b001;
    push_tick(it);
    it = calm_tick(0); it.rearm = 1'b1;
    push_tick(it);
    it = calm_tick(0); it.wrist_mode = 2'd1; it.wrist_torque = 16'sh8000; it.send_fail = 3'b111;
    push_tick(it);

    // Random phases, each with fresh settings loaded while the block is idle.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_quiet();
      if (p < 3) begin
        snd_idle = 22; rcv_idle = 47;
      end else if (p < 6) begin
        snd_idle = 47; rcv_idle = 22;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      load_cfg(phase_cfg(p));
      // long receiver hold-off while ticks keep coming: pipeline fills, input stalls
      if (p == 1 || p == 4) stall_reqs = stall_reqs + 1;
      counted = 0;
      while (counted < PHASE_TICKS) begin
        it = random_tick();
        was_armed = gen_st.armed;
        push_tick(it);
        if (was_armed || it.rearm) counted++;
      end
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tick driver: offers the next pending tick at the falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      // current tick was transferred (or nothing was offered): move on
      if (!in_vld || in_acc_cnt == in_sent_cnt) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
          in_dat <= tick_q.pop_front();
          in_vld <= 1'b1;
          in_sent_cnt = in_sent_cnt + 1;
        end else begin
          in_vld <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random back-pressure plus the occasional long hold-off.
  always @(negedge clk) begin
    if (stall_seen != stall_reqs) begin
      stall_seen = stall_reqs;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_rdy <= 1'b0;
    end else begin
      out_rdy <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: tracks config writes, predicts each accepted tick, checks verdicts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tick_res_t r;
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      chk_st      = '0;
      chk_st.code = FAULT_NONE;
      chk_cfg     = default_cfg();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          REG_SHOULDER_LIMIT: chk_cfg.lim[0]  = cfg_ch.data.value[LIMIT_W-1:0];
          REG_ELBOW_LIMIT:    chk_cfg.lim[1]  = cfg_ch.data.value[LIMIT_W-1:0];
          REG_WRIST_LIMIT:    chk_cfg.lim[2]  = cfg_ch.data.value[LIMIT_W-1:0];
          REG_OVERLOAD_TICKS: chk_cfg.ovl_thr = cfg_ch.data.value[TICKS_W-1:0];
          REG_TX_FAIL_TICKS:  chk_cfg.tx_thr  = cfg_ch.data.value[TICKS_W-1:0];
          REG_FB_TIMEOUT:     chk_cfg.fb_to   = cfg_ch.data.value[AGE_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (verdict_q.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result running=%0b code=%0d event=%0b",
                   $time, got.running, got.fault_code, got.fault_event);
        end else begin
          want = verdict_q.pop_front();
          if (want.running !== got.running || want.fault_code !== got.fault_code ||
              want.fault_event !== got.fault_event) begin
            errors = errors + 1;
            if (errors <= 50)
              $display({"%0t: mismatch expected running=%0b code=%0d event=%0b,",
                        " got running=%0b code=%0d event=%0b"},
                       $time, want.running, want.fault_code, want.fault_event,
                       got.running, got.fault_code, got.fault_event);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        r      = supervise_tick(chk_st, chk_cfg, in_ch.data);
        chk_st = r.st;
        verdict_q.push_back(r.verdict);
        in_acc_cnt = in_acc_cnt + 1;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

/* filelist.f */
rtl/jfs_pkg.sv
rtl/jfs_stream_if.sv
rtl/joint_fault_supervisor.sv
sim/testbench.sv
